FILE: src/pce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_pkg: shared types and constants for the piecewise cubic evaluator
// Holds the segment table geometry, the table entry layout and the codes
// used on the stream and configuration ports.
// ----------------------------------------------------------------------------
package pce_pkg;

    // Segment table geometry
    localparam int MAX_SEGMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    // Q16.16 value width and fraction bits
    localparam int VAL_W  = 32;
    localparam int FRAC_W = 16;

    // Item kinds carried in s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Configuration register indexes
    localparam logic [0:0] CFG_SEG_COUNT = 1'b0;
    localparam logic [0:0] CFG_CLAMP     = 1'b1;

    // One table entry: span and cubic coefficients a..d
    typedef struct packed {
        logic signed [VAL_W-1:0] left_edge;
        logic signed [VAL_W-1:0] right_edge;
        logic signed [VAL_W-1:0] coef_a;
        logic signed [VAL_W-1:0] coef_b;
        logic signed [VAL_W-1:0] coef_c;
        logic signed [VAL_W-1:0] coef_d;
    } seg_entry_t;

endpackage

FILE: src/piecewise_cubic_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_cubic_evaluator: Q16.16 piecewise cubic evaluation
// Segment table write, sample clamp, linear segment search and Horner
// evaluation on one shared multiplier.
// ----------------------------------------------------------------------------
// A segment write beat is taken in the idle state. An evaluate beat on an
// empty table goes straight to the output state. Otherwise an evaluate beat
// reads the span bounds, searches the segments in index order and then runs
// the Horner steps; it runs longer the later the hit segment lies, and
// longest when no segment holds the sample. The search reads one table entry
// per cycle from the single read port, and the three Horner steps share the
// one 32x33 multiplier (a multiply state, then a shift/add/saturate state).
// s_tready is low while an evaluation runs; a finished result waits in the
// output register while the next beat is taken, and a second result holds
// the block until the first one leaves.
// ----------------------------------------------------------------------------
module piecewise_cubic_evaluator
    import pce_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] seg_index, [35:4] left_edge, [67:36] right_edge,
    // [99:68] coef_cubic, [131:100] coef_square, [163:132] coef_linear,
    // [195:164] coef_offset, [227:196] sample_x, [231:228] zero
    input  logic [231:0] s_tdata,
    // [0] operation
    input  logic         s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] result_value, [35:32] hit_segment, [39:36] zero
    output logic [39:0]  m_tdata,
    // [0] table_empty, [1] value_saturated
    output logic [1:0]   m_tuser,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [4:0]   cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LO    = 8'b0000_0010,
        ST_HI    = 8'b0000_0100,
        ST_SRCH  = 8'b0000_1000,
        ST_FETCH = 8'b0001_0000,
        ST_MUL   = 8'b0010_0000,
        ST_ACC   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    localparam int SUM_W  = 2 * VAL_W + 2 - FRAC_W;
    localparam logic [1:0] LAST_STAGE = 2'd2;

    state_t state_reg, state_next;

    // configuration
    logic [CNT_W-1:0] seg_count_reg;
    logic             clamp_reg;

    // datapath registers
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [VAL_W-1:0]   x_reg;
    logic signed [VAL_W-1:0]   lo_reg;
    logic [IDX_W-1:0]          k_reg;
    logic [IDX_W-1:0]          hit_reg;
    logic signed [VAL_W:0]     dx_reg;
    logic signed [VAL_W-1:0]   acc_reg;
    logic signed [VAL_W-1:0]   coef_b_reg;
    logic signed [VAL_W-1:0]   coef_c_reg;
    logic signed [VAL_W-1:0]   coef_d_reg;
    logic signed [2*VAL_W:0]   prod_reg;
    logic [1:0]                stage_reg;
    logic                      sat_reg;
    logic                      empty_reg;

    // output register
    logic                      m_valid_reg;
    logic [VAL_W-1:0]          res_value_reg;
    logic [IDX_W-1:0]          res_hit_reg;
    logic                      res_empty_reg;
    logic                      res_sat_reg;

    // table ports
    logic             tbl_wr_en;
    seg_entry_t       tbl_wr_data;
    logic [IDX_W-1:0] tbl_rd_addr;
    seg_entry_t       tbl_rd_data;

    logic             in_beat;
    logic             is_eval;
    logic [CNT_W-1:0] cnt_in;
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] last_idx;
    logic             seg_match;
    logic             at_last;
    logic [IDX_W-1:0] fallback_idx;
    logic signed [VAL_W-1:0] x_clamped;
    logic signed [VAL_W-1:0] addend;
    logic signed [SUM_W-1:0] horner_sum;
    logic             sum_ovf;
    logic signed [VAL_W-1:0] sum_sat;
    logic             out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid && s_tready;
    assign is_eval   = (s_tuser == OP_EVAL);

    // ------------------------------------------------------------------
    // Segment table
    // ------------------------------------------------------------------
    assign tbl_wr_en              = in_beat && (s_tuser == OP_WRITE);
    assign tbl_wr_data.left_edge  = s_tdata[35:4];
    assign tbl_wr_data.right_edge = s_tdata[67:36];
    assign tbl_wr_data.coef_a     = s_tdata[99:68];
    assign tbl_wr_data.coef_b     = s_tdata[131:100];
    assign tbl_wr_data.coef_c     = s_tdata[163:132];
    assign tbl_wr_data.coef_d     = s_tdata[195:164];

    pce_seg_table u_seg_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (s_tdata[3:0]),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // ------------------------------------------------------------------
    // Search helpers
    // ------------------------------------------------------------------
    assign cnt_in = (seg_count_reg > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                           : seg_count_reg;
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign at_last  = (k_reg == last_idx);
    assign fallback_idx = (x_reg < lo_reg) ? '0 : last_idx;

    assign seg_match = (x_reg >= tbl_rd_data.left_edge) &&
                       (x_reg <= tbl_rd_data.right_edge);

    // clamp to [first left, last right]; lower edge checked first
    always_comb begin
        x_clamped = x_reg;
        if (clamp_reg) begin
            if (x_reg < lo_reg) begin
                x_clamped = lo_reg;
            end else if (x_reg > tbl_rd_data.right_edge) begin
                x_clamped = tbl_rd_data.right_edge;
            end
        end
    end

    // table read address per state
    always_comb begin
        tbl_rd_addr = '0;
        unique case (state_reg)
            ST_LO:   tbl_rd_addr = last_idx;
            ST_SRCH: begin
                if (!at_last) begin
                    tbl_rd_addr = k_reg + IDX_W'(1);
                end else begin
                    tbl_rd_addr = fallback_idx;
                end
            end
            default: tbl_rd_addr = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Horner step: floor shift of product, add, saturate
    // ------------------------------------------------------------------
    always_comb begin
        unique case (stage_reg)
            2'd0:    addend = coef_b_reg;
            2'd1:    addend = coef_c_reg;
            default: addend = coef_d_reg;
        endcase
    end

    assign horner_sum = SUM_W'(prod_reg >>> FRAC_W) + SUM_W'(addend);
    assign sum_ovf    = (horner_sum[SUM_W-1:VAL_W-1] != '0) &&
                        (horner_sum[SUM_W-1:VAL_W-1] != '1);
    assign sum_sat    = !sum_ovf ? horner_sum[VAL_W-1:0] :
                        (horner_sum[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                             : {1'b0, {(VAL_W-1){1'b1}}});

    assign out_free = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat && is_eval) begin
                    state_next = (cnt_in == '0) ? ST_OUT : ST_LO;
                end
            end
            ST_LO:    state_next = ST_HI;
            ST_HI:    state_next = ST_SRCH;
            ST_SRCH: begin
                if (seg_match) begin
                    state_next = ST_MUL;
                end else if (at_last) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = (stage_reg == LAST_STAGE) ? ST_OUT : ST_MUL;
            ST_OUT:   state_next = out_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            seg_count_reg <= '0;
            clamp_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            // result beat handshake
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SEG_COUNT: seg_count_reg <= cfg_data[CNT_W-1:0];
                    CFG_CLAMP:     clamp_reg     <= cfg_data[0];
                    default:       ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                x_reg     <= s_tdata[227:196];
                cnt_reg   <= cnt_in;
                acc_reg   <= '0;
                hit_reg   <= '0;
                sat_reg   <= 1'b0;
                empty_reg <= (cnt_in == '0);
            end
            ST_LO: begin
                lo_reg <= tbl_rd_data.left_edge;
            end
            ST_HI: begin
                x_reg <= x_clamped;
                k_reg <= '0;
            end
            ST_SRCH, ST_FETCH: begin
                if (state_reg == ST_SRCH && !seg_match) begin
                    k_reg   <= k_reg + IDX_W'(1);
                    hit_reg <= fallback_idx;
                end else begin
                    if (state_reg == ST_SRCH) begin
                        hit_reg <= k_reg;
                    end
                    dx_reg     <= (VAL_W+1)'(x_reg) - (VAL_W+1)'(tbl_rd_data.left_edge);
                    acc_reg    <= tbl_rd_data.coef_a;
                    coef_b_reg <= tbl_rd_data.coef_b;
                    coef_c_reg <= tbl_rd_data.coef_c;
                    coef_d_reg <= tbl_rd_data.coef_d;
                    stage_reg  <= '0;
                end
            end
            ST_MUL: begin
                prod_reg <= (2*VAL_W+1)'(acc_reg) * (2*VAL_W+1)'(dx_reg);
            end
            ST_ACC: begin
                acc_reg   <= sum_sat;
                sat_reg   <= sat_reg | sum_ovf;
                stage_reg <= stage_reg + 2'd1;
            end
            ST_OUT: begin
                if (out_free) begin
                    res_value_reg <= acc_reg;
                    res_hit_reg   <= hit_reg;
                    res_empty_reg <= empty_reg;
                    res_sat_reg   <= sat_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, res_hit_reg, res_value_reg};
    assign m_tuser  = {res_sat_reg, res_empty_reg};

endmodule

FILE: src/pce_seg_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_seg_table: segment table storage
// One write port and one read port with registered read data; each entry
// holds a full segment so one read returns span and coefficients together.
// ----------------------------------------------------------------------------
module pce_seg_table
    import pce_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  seg_entry_t       wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output seg_entry_t       rd_data
);

    seg_entry_t seg_mem_reg [MAX_SEGMENTS];
    seg_entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            seg_mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= seg_mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: bench/pce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_checker: result predictor and scoreboard for the piecewise cubic evaluator
// Watches the configuration, input and result channels. Keeps its own copy of
// the segment table and registers, computes each evaluation in Q16.16 and
// compares every result beat field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module pce_checker
    import pce_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [231:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [4:0]   cfg_data,
    output int           mismatch_count,
    output int           results_owed
);

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] hit;
        logic             empty;
        logic             sat;
    } cubic_result_t;

    // Shadow of the block's table and registers
    seg_entry_t    seg_tab [MAX_SEGMENTS];
    logic [4:0]    seg_count;
    logic          clamp_on;
    cubic_result_t owed_results [$];

    initial begin
        foreach (seg_tab[i]) seg_tab[i] = '0;
        seg_count      = '0;
        clamp_on       = 1'b0;
        mismatch_count = 0;
        results_owed   = 0;
    end

    function automatic longint to_long(logic [VAL_W-1:0] v);
        return longint'($signed(v));
    endfunction

    // One Horner stage: multiply, floor shift, add, clip to 32 bits
    function automatic longint horner_step(longint acc, longint dx, logic [VAL_W-1:0] add,
                                           inout logic sat);
        longint p;
        p = (acc * dx) >>> FRAC_W;
        p = p + to_long(add);
        if (p > 64'sh7FFF_FFFF) begin
            p   = 64'sh7FFF_FFFF;
            sat = 1'b1;
        end else if (p < -64'sh8000_0000) begin
            p   = -64'sh8000_0000;
            sat = 1'b1;
        end
        return p;
    endfunction

    // Clamp, search, fall back, then evaluate the chosen cubic
    function automatic cubic_result_t evaluate_sample(logic [VAL_W-1:0] sample);
        cubic_result_t res;
        int            n;
        int            k;
        int            sel;
        longint        x;
        longint        lo;
        longint        hi;
        longint        dx;
        longint        acc;
        logic          sat;
        res = '0;
        n = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
        if (n == 0) begin
            res.empty = 1'b1;
            return res;
        end
        x  = to_long(sample);
        lo = to_long(seg_tab[0].left_edge);
        hi = to_long(seg_tab[n - 1].right_edge);
        if (clamp_on) begin
            if (x < lo) x = lo;
            else if (x > hi) x = hi;
        end
        sel = -1;
        for (k = 0; k < n; k++) begin
            if (sel < 0 && x >= to_long(seg_tab[k].left_edge)
                        && x <= to_long(seg_tab[k].right_edge))
                sel = k;
        end
        if (sel < 0) sel = (x < lo) ? 0 : n - 1;
        dx  = x - to_long(seg_tab[sel].left_edge);
        sat = 1'b0;
        acc = to_long(seg_tab[sel].coef_a);
        acc = horner_step(acc, dx, seg_tab[sel].coef_b, sat);
        acc = horner_step(acc, dx, seg_tab[sel].coef_c, sat);
        acc = horner_step(acc, dx, seg_tab[sel].coef_d, sat);
        res.value = VAL_W'(acc);
        res.hit   = IDX_W'(sel);
        res.sat   = sat;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h, expected %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Sample all three channels at the rising edge
    always @(posedge aclk) begin : watch
        cubic_result_t want;
        if (!aresetn) begin
            seg_count = '0;
            clamp_on  = 1'b0;
            owed_results.delete();
        end else begin
            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result beat with none owed", 64'(m_tdata), 64'd0);
                end else begin
                    want = owed_results.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch("result_value", 64'(m_tdata[31:0]), 64'(want.value));
                    if (m_tdata[35:32] !== want.hit)
                        report_mismatch("hit_segment", 64'(m_tdata[35:32]), 64'(want.hit));
                    if (m_tdata[39:36] !== 4'b0)
                        report_mismatch("tdata padding", 64'(m_tdata[39:36]), 64'd0);
                    if (m_tuser[0] !== want.empty)
                        report_mismatch("table_empty", 64'(m_tuser[0]), 64'(want.empty));
                    if (m_tuser[1] !== want.sat)
                        report_mismatch("value_saturated", 64'(m_tuser[1]), 64'(want.sat));
                end
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SEG_COUNT: seg_count = cfg_data;
                    CFG_CLAMP:     clamp_on  = cfg_data[0];
                    default: ;
                endcase
            end
            // input beat: table write or evaluation
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_WRITE) begin
                    seg_tab[s_tdata[3:0]].left_edge  = s_tdata[35:4];
                    seg_tab[s_tdata[3:0]].right_edge = s_tdata[67:36];
                    seg_tab[s_tdata[3:0]].coef_a     = s_tdata[99:68];
                    seg_tab[s_tdata[3:0]].coef_b     = s_tdata[131:100];
                    seg_tab[s_tdata[3:0]].coef_c     = s_tdata[163:132];
                    seg_tab[s_tdata[3:0]].coef_d     = s_tdata[195:164];
                end else begin
                    owed_results.insert(owed_results.size(),
                                        evaluate_sample(s_tdata[227:196]));
                end
            end
        end
        results_owed = owed_results.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the piecewise cubic evaluator
// Loads segment tables of several shapes (sorted, gapped, inverted, random),
// switches count and clamp between phases, and streams evaluations at edges,
// outside the span and at the extremes under random idling and back-pressure.
// Prediction and comparison live in pce_checker.
// ----------------------------------------------------------------------------
module testbench;
    import pce_pkg::*;

    typedef enum int {TBL_CONTIG, TBL_GAPPED, TBL_REVERSED, TBL_NOISE} table_style_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [231:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [4:0]   cfg_data;

    int           mismatch_count;
    int           results_owed;
    logic         s_took   = 1'b0;
    logic         cfg_took = 1'b0;
    int           idle_pct   = 0;
    int           stall_pct  = 0;
    int           hold_left  = 0;
    int           items_sent = 0;

    // Edges as written, used only to aim samples
    logic [31:0]  tab_left  [MAX_SEGMENTS];
    logic [31:0]  tab_right [MAX_SEGMENTS];

    piecewise_cubic_evaluator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pce_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Handshake outcomes, read back at the falling edge
    always @(posedge aclk) begin
        s_took   <= s_tvalid && s_tready;
        cfg_took <= cfg_valid && cfg_ready;
    end

    // Result side: random back-pressure plus an occasional long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("FAIL piecewise_cubic_evaluator");
        $finish;
    end

    // One input beat; leaves tvalid high so back-to-back beats need no toggle
    task automatic send_item(logic op, logic [3:0] idx, logic [31:0] left, logic [31:0] right,
                             logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                             logic [31:0] x);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, x, d, c, b, a, right, left, idx};
        @(negedge aclk);
        while (!s_took) @(negedge aclk);
        items_sent++;
    endtask

    task automatic write_segment(logic [3:0] idx, logic [31:0] left, logic [31:0] right,
                                 logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 logic [31:0] d);
        tab_left[idx]  = left;
        tab_right[idx] = right;
        send_item(OP_WRITE, idx, left, right, a, b, c, d, $urandom);
    endtask

    task automatic eval_sample(logic [31:0] x);
        send_item(OP_EVAL, 4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, x);
    endtask

    task automatic cfg_write(logic [0:0] idx, logic [4:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        while (!cfg_took) @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop the stream, wait for all results, then let a late write retire
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (results_owed != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // Mostly small coefficients, some full range, some extremes
    function automatic logic [31:0] pick_coef();
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // Samples at edges, just past them, inside segments, outside the span
    function automatic logic [31:0] pick_sample(int n_eff);
        int          k;
        longint      lo;
        longint      span;
        logic [31:0] x;
        if (n_eff == 0) return $urandom;
        k = $urandom_range(n_eff - 1);
        case ($urandom_range(15))
            0:  x = $urandom;
            1:  x = 32'h8000_0000;
            2:  x = 32'h7FFF_FFFF;
            3:  x = tab_left[k];
            4:  x = tab_right[k];
            5:  x = tab_left[k] - 32'd1;
            6:  x = tab_right[k] + 32'd1;
            7:  x = tab_left[0] - $urandom_range(1, 32'h0010_0000);
            8:  x = tab_right[n_eff - 1] + $urandom_range(1, 32'h0010_0000);
            default: begin
                lo   = longint'($signed(tab_left[k]));
                span = longint'($signed(tab_right[k])) - lo;
                if (span <= 0) x = tab_left[k];
                else x = 32'(lo + (span * $urandom_range(1023)) / 1023);
            end
        endcase
        return x;
    endfunction

    // Fill entries 0..n-1 in a rotated order
    task automatic load_table(int n, table_style_t style);
        logic [31:0] lo_at [MAX_SEGMENTS];
        logic [31:0] hi_at [MAX_SEGMENTS];
        longint      edge_at;
        longint      step;
        int unsigned step_max;
        int          k;
        int          off;
        int          idx;
        step_max = ($urandom_range(1) == 0) ? 32'h0004_0000 : 32'h0400_0000;
        edge_at  = longint'($urandom_range(32'h7FFF_FFFF) >> 1) - 64'sh4000_0000;
        for (k = 0; k < n; k++) begin
            step = longint'($urandom_range(1, step_max));
            case (style)
                TBL_GAPPED: begin
                    lo_at[k] = 32'(edge_at);
                    hi_at[k] = 32'(edge_at + step / 2);
                    edge_at  = edge_at + step;
                end
                TBL_REVERSED: begin
                    lo_at[k] = 32'(edge_at);
                    hi_at[k] = 32'(edge_at - step / 2);
                    edge_at  = edge_at - step;
                end
                TBL_NOISE: begin
                    lo_at[k] = $urandom;
                    hi_at[k] = $urandom;
                end
                default: begin
                    // neighbors share a boundary point
                    lo_at[k] = 32'(edge_at);
                    edge_at  = edge_at + step;
                    hi_at[k] = 32'(edge_at);
                end
            endcase
        end
        off = $urandom_range(n - 1);
        for (k = 0; k < n; k++) begin
            idx = (k + off) % n;
            write_segment(4'(idx), lo_at[idx], hi_at[idx], pick_coef(), pick_coef(),
                          pick_coef(), pick_coef());
        end
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        int           phase;
        int           n;
        int           cnt;
        int           n_eff;
        int           k;
        int           r;
        table_style_t style;
        logic         clamp_bit;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_WRITE;
        cfg_valid = 1'b0;
        cfg_index = CFG_SEG_COUNT;
        cfg_data  = '0;
        aresetn   = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty table right after reset
        eval_sample(32'h0000_0000);
        eval_sample(32'h8000_0000);

        // unit-wide sorted segments from -8.0 to 8.0, extremes at both ends
        for (k = 0; k < MAX_SEGMENTS; k++) begin
            if (k == 0)
                write_segment(4'(k), 32'((k - 8) * 65536), 32'((k - 7) * 65536),
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            else if (k == MAX_SEGMENTS - 1)
                write_segment(4'(k), 32'((k - 8) * 65536), 32'((k - 7) * 65536),
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            else
                write_segment(4'(k), 32'((k - 8) * 65536), 32'((k - 7) * 65536),
                              32'(k * 4096), 32'(-k * 16384), 32'h0001_0000,
                              32'(k * 65536));
        end
        quiesce();
        cfg_write(CFG_SEG_COUNT, 5'd16);
        cfg_write(CFG_CLAMP, 5'd0);
        eval_sample(32'hFFF7_0000);     // below span: first segment
        eval_sample(32'h0009_0000);     // above span: last segment
        eval_sample(32'hFFF9_0000);     // shared boundary: lower index wins
        eval_sample(32'h7FFF_FFFF);
        eval_sample(32'h8000_0000);
        quiesce();
        cfg_write(CFG_CLAMP, 5'd1);
        eval_sample(32'hFFF7_0000);
        eval_sample(32'h7FFF_FFFF);
        quiesce();
        cfg_write(CFG_SEG_COUNT, 5'd31);  // count past the table
        eval_sample(32'h0004_0000);

        // random phases: new table, new registers, a burst of evaluations
        for (phase = 0; items_sent < 1300; phase++) begin
            quiesce();
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 45; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            n = ($urandom_range(3) == 0) ? MAX_SEGMENTS : $urandom_range(1, 6);
            if (phase == 0) n = MAX_SEGMENTS;
            if (phase == 6) n = 1;
            r = $urandom_range(9);
            style = (r < 6) ? TBL_CONTIG : (r < 8) ? TBL_GAPPED :
                    (r == 8) ? TBL_NOISE : TBL_REVERSED;
            if (phase == 1) style = TBL_REVERSED;
            if (phase == 3) style = TBL_NOISE;
            load_table(n, style);
            quiesce();

            cnt = n;
            if (phase == 4) cnt = 0;
            else if (phase == 5) cnt = 31;
            else if ($urandom_range(9) == 0) cnt = $urandom_range(17, 31);
            cfg_write(CFG_SEG_COUNT, 5'(cnt));
            clamp_bit = (phase == 1) ? 1'b1 : 1'($urandom_range(1));
            cfg_write(CFG_CLAMP, {4'($urandom), clamp_bit});
            n_eff = (cnt > MAX_SEGMENTS) ? MAX_SEGMENTS : cnt;

            // long receiver hold-off so the block backs up into its input
            if (phase == 2) hold_left = 400;

            repeat (60) begin
                if ($urandom_range(19) == 0)
                    write_segment(4'($urandom), $urandom, $urandom, pick_coef(), pick_coef(),
                                  pick_coef(), pick_coef());
                else
                    eval_sample(pick_sample(n_eff));
            end
        end

        quiesce();
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("PASS piecewise_cubic_evaluator");
        else
            $display("FAIL piecewise_cubic_evaluator");
        $finish;
    end

endmodule
